### sv/wma_pkg.sv
// Shared types and constants of the weighted moving average filter.
package wma_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int WSIZE_W    = 4;
    localparam int WSLOT_W    = 16;
    localparam int WPR        = 4;
    localparam int AVG_W      = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHTS_LOW  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHTS_HIGH = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MAC   = 6'b000010,
        ST_FLUSH = 6'b000100,
        ST_PREP  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } wma_state_t;

    typedef struct packed {
        logic start;
        logic mac_step;
        logic flush;
        logic div_prep;
        logic div_step;
        logic finish;
    } wma_cmd_t;

    typedef struct packed {
        logic mac_last;
        logic div_last;
        logic run_div;
    } wma_stat_t;

endpackage

### sv/wma_datapath.sv
// Datapath: configuration, sample ring, multiply-accumulate and restoring divider.
module wma_datapath
    import wma_pkg::*;
#(
    parameter int MAX_WINDOW  = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  wma_cmd_t                      cmd,
    output wma_stat_t                     stat,
    output logic signed [AVG_W-1:0]       average,
    output logic                          window_full,
    output logic                          weight_sum_zero
);

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int WSUM_W = WEIGHT_BITS + PTR_W;
    localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS + 1;
    localparam int ACC_W  = PROD_W + PTR_W;
    localparam int DCNT_W = $clog2(SAMPLE_BITS);

    logic [WSIZE_W-1:0]            window_size_reg;
    logic [CFG_DATA_W-1:0]         weights_low_reg;
    logic [CFG_DATA_W-1:0]         weights_high_reg;
    logic signed [SAMPLE_BITS-1:0] store_reg [MAX_WINDOW];
    logic [PTR_W-1:0]              wp_reg;
    logic [CNT_W-1:0]              fill_reg;
    logic [PTR_W-1:0]              rd_reg;
    logic [PTR_W-1:0]              widx_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic [WSUM_W-1:0]             wsum_reg;
    logic [WSUM_W-1:0]             rem_reg;
    logic [SAMPLE_BITS-1:0]        quo_reg;
    logic                          neg_reg;
    logic [DCNT_W-1:0]             dcnt_reg;
    logic signed [AVG_W-1:0]       held_reg;
    logic                          full_out_reg;
    logic                          wsz_out_reg;

    logic [CNT_W-1:0]              size;
    logic [WEIGHT_BITS-1:0]        w_arr [MAX_WINDOW];
    logic [PTR_W-1:0]              wp_eff;
    logic [CNT_W-1:0]              wp_inc;
    logic [PTR_W-1:0]              wp_next;
    logic [CNT_W-1:0]              fill_next;
    logic [CNT_W-1:0]              rd_inc;
    logic [PTR_W-1:0]              rd_next;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [ACC_W-1:0]       acc_next;
    logic [ACC_W-1:0]              mag;
    logic [WSUM_W:0]               trial;
    logic [WSUM_W:0]               diff;
    logic [WSUM_W-1:0]             rem_next;
    logic [SAMPLE_BITS-1:0]        quo_next;
    logic [SAMPLE_BITS-1:0]        res;
    logic signed [AVG_W-1:0]       held_next;
    logic                          full;
    logic                          wsum_zero;

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            size = CNT_W'(1);
        end
        else if (window_size_reg > WSIZE_W'(MAX_WINDOW))
        begin
            size = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            size = window_size_reg[CNT_W-1:0];
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            if (k < WPR)
            begin
                w_arr[k] = weights_low_reg[(k % WPR)*WSLOT_W +: WEIGHT_BITS];
            end
            else
            begin
                w_arr[k] = weights_high_reg[(k % WPR)*WSLOT_W +: WEIGHT_BITS];
            end
        end
    end

    assign wp_eff    = (CNT_W'(wp_reg) >= size) ? '0 : wp_reg;
    assign wp_inc    = CNT_W'(wp_eff) + CNT_W'(1);
    assign wp_next   = (wp_inc >= size) ? '0 : wp_inc[PTR_W-1:0];
    assign fill_next = (fill_reg < size) ? fill_reg + CNT_W'(1) : fill_reg;
    assign rd_inc    = CNT_W'(rd_reg) + CNT_W'(1);
    assign rd_next   = (rd_inc >= size) ? '0 : rd_inc[PTR_W-1:0];

    assign prod_next = $signed(store_reg[rd_reg]) * $signed({1'b0, w_arr[widx_reg]});
    assign acc_next  = acc_reg + ACC_W'(prod_reg);

    assign mag      = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign trial    = {rem_reg, quo_reg[SAMPLE_BITS-1]};
    assign diff     = trial - {1'b0, wsum_reg};
    assign rem_next = diff[WSUM_W] ? trial[WSUM_W-1:0] : diff[WSUM_W-1:0];
    assign quo_next = {quo_reg[SAMPLE_BITS-2:0], ~diff[WSUM_W]};
    assign res      = neg_reg ? (~quo_reg + SAMPLE_BITS'(1)) : quo_reg;

    always_comb
    begin
        for (int b = 0; b < AVG_W; b++)
        begin
            held_next[b] = res[(b < SAMPLE_BITS) ? b : SAMPLE_BITS-1];
        end
    end

    assign full      = (fill_reg >= size);
    assign wsum_zero = (wsum_reg == '0);

    assign stat.mac_last = ((CNT_W'(widx_reg) + CNT_W'(1)) == size);
    assign stat.div_last = (dcnt_reg == DCNT_W'(SAMPLE_BITS - 1));
    assign stat.run_div  = full && !wsum_zero;

    assign average         = held_reg;
    assign window_full     = full_out_reg;
    assign weight_sum_zero = wsz_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= WSIZE_W'(8);
            weights_low_reg  <= '0;
            weights_high_reg <= '0;
            wp_reg           <= '0;
            fill_reg         <= '0;
            rd_reg           <= '0;
            widx_reg         <= '0;
            dcnt_reg         <= '0;
            held_reg         <= '0;
            full_out_reg     <= 1'b0;
            wsz_out_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_WINDOW_SIZE:
                    begin
                        window_size_reg <= cfg_wdata[WSIZE_W-1:0];
                        wp_reg          <= '0;
                        fill_reg        <= '0;
                    end
                    REG_WEIGHTS_LOW:  weights_low_reg  <= cfg_wdata;
                    REG_WEIGHTS_HIGH: weights_high_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.start)
            begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
                rd_reg   <= wp_next;
                widx_reg <= '0;
            end
            if (cmd.mac_step)
            begin
                rd_reg   <= rd_next;
                widx_reg <= widx_reg + PTR_W'(1);
            end
            if (cmd.div_prep)
            begin
                dcnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end
            if (cmd.finish)
            begin
                if (stat.run_div)
                begin
                    held_reg <= held_next;
                end
                full_out_reg <= full;
                wsz_out_reg  <= wsum_zero;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            store_reg[wp_eff] <= sample;
            prod_reg          <= '0;
            acc_reg           <= '0;
            wsum_reg          <= '0;
        end
        if (cmd.mac_step)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
            wsum_reg <= wsum_reg + WSUM_W'(w_arr[widx_reg]);
        end
        if (cmd.flush)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.div_prep)
        begin
            rem_reg <= mag[SAMPLE_BITS +: WSUM_W];
            quo_reg <= mag[SAMPLE_BITS-1:0];
            neg_reg <= acc_reg[ACC_W-1];
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

### sv/wma_ctrl.sv
// Controller: sequences accumulation and division and owns both handshakes.
module wma_ctrl
    import wma_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  wma_stat_t stat,
    output wma_cmd_t  cmd
);

    wma_state_t state_reg;
    wma_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (stat.mac_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (stat.run_div)
                begin
                    cmd.div_prep = 1'b1;
                    state_next   = ST_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### sv/weighted_moving_average.sv
// Top level of the weighted moving average filter.
//
//   channel   direction   handshake              payload
//   config    in          cfg_wr_en              cfg_addr, cfg_wdata
//   input     in          in_valid / in_ready    sample
//   output    out         out_valid / out_ready  average, window_full, weight_sum_zero
//
// Each input beat is accumulated over the window on the shared multiplier and
// then divided by the weight sum on the one-bit-per-cycle divider, which is
// skipped while the window is filling or the weight sum is zero. A new beat is taken
// only once the last is finished. A finished beat waits in the output register while
// the next input beat is taken; a new result waits until the previous one is taken.
// Reset clears the window count, held average and weights; the window size becomes 8.
module weighted_moving_average
    import wma_pkg::*;
#(
    parameter int MAX_WINDOW  = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [AVG_W-1:0]       average,
    output logic                          window_full,
    output logic                          weight_sum_zero
);

    wma_cmd_t  cmd;
    wma_stat_t stat;

    wma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wma_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .sample          (sample),
        .cmd             (cmd),
        .stat            (stat),
        .average         (average),
        .window_full     (window_full),
        .weight_sum_zero (weight_sum_zero)
    );

endmodule

### tb/tb_weighted_moving_average.sv
// Self-checking testbench for the weighted moving average filter.
module tb_weighted_moving_average;
    timeunit 1ns;
    timeprecision 1ps;

    import wma_pkg::*;

    localparam int WINDOW_DEPTH = 8;
    localparam int SAMPLE_W     = 16;

    localparam bit [2:0] SET_SIZE = 3'(1 << REG_WINDOW_SIZE);
    localparam bit [2:0] SET_LOW  = 3'(1 << REG_WEIGHTS_LOW);
    localparam bit [2:0] SET_HIGH = 3'(1 << REG_WEIGHTS_HIGH);
    localparam bit [2:0] SET_ALL  = SET_SIZE | SET_LOW | SET_HIGH;

    typedef struct packed {
        logic signed [AVG_W-1:0] average;
        logic                    window_full;
        logic                    weight_sum_zero;
    } wma_result_t;

    class wma_scoreboard;
        logic [WSIZE_W-1:0]         size_reg;
        logic [CFG_DATA_W-1:0]      weights_lo;
        logic [CFG_DATA_W-1:0]      weights_hi;
        logic signed [SAMPLE_W-1:0] ring [WINDOW_DEPTH];
        int unsigned                wr_ptr;
        int unsigned                fill;
        logic signed [AVG_W-1:0]    held;
        wma_result_t                due_results [$];
        int                         mismatches;
        int                         checked;
        int                         full_seen;
        int                         zero_seen;

        function new();
            size_reg   = WSIZE_W'(WINDOW_DEPTH);
            weights_lo = '0;
            weights_hi = '0;
            wr_ptr     = 0;
            fill       = 0;
            held       = '0;
            mismatches = 0;
            checked    = 0;
            full_seen  = 0;
            zero_seen  = 0;
        endfunction

        function longint weight_of(int unsigned i);
            logic [CFG_DATA_W-1:0] bank;
            bank = (i < WPR) ? weights_lo : weights_hi;
            return longint'(bank[(i % WPR) * WSLOT_W +: WSLOT_W]);
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_WINDOW_SIZE:
                begin
                    size_reg = data[WSIZE_W-1:0];
                    fill     = 0;
                    wr_ptr   = 0;
                end
                REG_WEIGHTS_LOW:  weights_lo = data;
                REG_WEIGHTS_HIGH: weights_hi = data;
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] s);
            int unsigned size;
            int unsigned idx;
            longint      wsum;
            longint      total;
            wma_result_t r;
            size = (size_reg == 0) ? 1 : ((size_reg > WINDOW_DEPTH) ? WINDOW_DEPTH : size_reg);
            wsum = 0;
            for (int unsigned i = 0; i < size; i++)
                wsum += weight_of(i);
            if (wr_ptr >= size)
                wr_ptr = 0;
            ring[wr_ptr] = s;
            wr_ptr = (wr_ptr + 1 >= size) ? 0 : wr_ptr + 1;
            if (fill < size)
                fill++;
            if (fill >= size && wsum != 0)
            begin
                total = 0;
                for (int unsigned i = 0; i < size; i++)
                begin
                    idx = wr_ptr + i;
                    if (idx >= size)
                        idx -= size;
                    total += longint'(ring[idx]) * weight_of(i);
                end
                held = AVG_W'(total / wsum);
            end
            r.average         = held;
            r.window_full     = (fill >= size);
            r.weight_sum_zero = (wsum == 0);
            due_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(logic signed [AVG_W-1:0] avg, logic full, logic zero);
            wma_result_t want;
            if (due_results.size() == 0)
            begin
                report_mismatch($sformatf("result with no beat pending, average %0d", avg));
                return;
            end
            want = due_results.pop_front();
            checked++;
            if (want.window_full)
                full_seen++;
            if (want.weight_sum_zero)
                zero_seen++;
            if (avg !== want.average)
                report_mismatch($sformatf("result %0d: average %0d, want %0d",
                                          checked, avg, want.average));
            if (full !== want.window_full)
                report_mismatch($sformatf("result %0d: window_full %b, want %b",
                                          checked, full, want.window_full));
            if (zero !== want.weight_sum_zero)
                report_mismatch($sformatf("result %0d: weight_sum_zero %b, want %b",
                                          checked, zero, want.weight_sum_zero));
        endtask
    endclass

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]         cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]         cfg_wdata = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_W-1:0]    sample    = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [AVG_W-1:0]       average;
    logic                          window_full;
    logic                          weight_sum_zero;

    wma_scoreboard board = new();
    bit            calm  = 1'b0;
    int            samples_sent;
    int            settings_used;

    weighted_moving_average u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .average         (average),
        .window_full     (window_full),
        .weight_sum_zero (weight_sum_zero)
    );

    always #4 clk = ~clk;

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 24);
    endfunction

    function automatic logic [WSIZE_W-1:0] pick_size();
        if ($urandom_range(99) < 12)
            return $urandom_range(1) ? WSIZE_W'(0) : WSIZE_W'($urandom_range(15, WINDOW_DEPTH + 1));
        return WSIZE_W'($urandom_range(WINDOW_DEPTH, 1));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_weights();
        logic [CFG_DATA_W-1:0] w;
        int                    n;
        n = $urandom_range(9);
        if (n == 0)
            w = '0;
        else if (n < 4)
            w = {$urandom, $urandom};
        else
            for (int k = 0; k < WPR; k++)
                case ($urandom_range(5))
                    0:       w[k*WSLOT_W +: WSLOT_W] = '0;
                    1:       w[k*WSLOT_W +: WSLOT_W] = '1;
                    2:       w[k*WSLOT_W +: WSLOT_W] = 16'h8000;
                    3:       w[k*WSLOT_W +: WSLOT_W] = 16'h0001;
                    default: w[k*WSLOT_W +: WSLOT_W] = WSLOT_W'($urandom);
                endcase
        return w;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:
                case ($urandom_range(3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return -16'sd1;
                    default: return 16'sd0;
                endcase
            1:       return SAMPLE_W'(int'($urandom_range(20)) - 10);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_sample(s);
        samples_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        board.set_reg(addr, data);
    endtask

    task automatic load_settings(input bit [2:0] which, input logic [WSIZE_W-1:0] size,
                                 input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi);
        settle();
        if (which[REG_WEIGHTS_LOW])
            put_reg(REG_WEIGHTS_LOW, lo);
        if (which[REG_WEIGHTS_HIGH])
            put_reg(REG_WEIGHTS_HIGH, hi);
        if (which[REG_WINDOW_SIZE])
            put_reg(REG_WINDOW_SIZE, CFG_DATA_W'(size));
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(average, window_full, weight_sum_zero);
        out_ready <= !take_break();
    end

    initial
    begin : stimulus
        int       phase;
        int       count;
        bit [2:0] which;
        samples_sent  = 0;
        settings_used = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: window of eight, all weights zero.
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);

        load_settings(SET_ALL, WSIZE_W'(2), '1, '1);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);

        load_settings(SET_ALL, WSIZE_W'(1), 64'h1, '0);
        send_sample(-16'sd1);
        send_sample(16'sd1);

        // Only weights outside the window are nonzero, so the average is held.
        load_settings(SET_SIZE | SET_LOW, WSIZE_W'(2), 64'hFFFF_FFFF_0000_0000, '0);
        send_sample(16'sd5);
        send_sample(16'sd6);
        send_sample(16'sd7);

        load_settings(SET_SIZE | SET_LOW, WSIZE_W'(0), 64'h8000, '0);
        send_sample(16'sd12345);

        load_settings(SET_ALL, '1, 64'h0004_0003_0002_0001, 64'h8000_FFFF_0000_7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);

        phase = 0;
        while (samples_sent < 1320)
        begin
            phase++;
            which = SET_ALL;
            if ($urandom_range(3) == 0)
                which[REG_WINDOW_SIZE] = 1'b0;
            load_settings(which, pick_size(), pick_weights(), pick_weights());
            calm  = (phase == 8);
            count = calm ? 150 : $urandom_range(60, 5);
            repeat (count) send_sample(pick_sample());
            calm = 1'b0;
        end

        settle();
        repeat (32) @(posedge clk);
        $display("Sent %0d samples under %0d register settings.", samples_sent, settings_used);
        $display("Checked %0d results: %0d with a full window, %0d with a zero weight sum.",
                 board.checked, board.full_seen, board.zero_seen);
        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Timed out with %0d results still pending.", board.due_results.size());
        $display("FAIL");
        $finish;
    end

endmodule
